[rtl/pmft_pkg.sv]
// ----------------------------------------------------------------------------
// pmft_pkg
// Shared types and constants for the page mapped flash translation engine.
// ----------------------------------------------------------------------------
package pmft_pkg;

    localparam int PAGES_IN_BLOCK = 128;
    localparam int BLOCK_TOTAL    = 1024;
    localparam int PHYS_PAGES     = PAGES_IN_BLOCK * BLOCK_TOTAL;
    localparam int OFF_W          = $clog2(PAGES_IN_BLOCK);
    localparam int BLK_W          = $clog2(BLOCK_TOTAL);
    localparam int PBA_W          = OFF_W + BLK_W;
    localparam int MAP_W          = PBA_W + 1;

    localparam logic [17:0] LPC_RESET  = 18'd117964;
    localparam logic [17:0] PHYS_COUNT = 18'(PHYS_PAGES);
    localparam logic [31:0] ERASE_MAX  = 32'hFFFF_FFFF;
    localparam logic [7:0]  INV_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_UNMAPPED  = 3'd3,
        ST_NOT_VALID = 3'd4,
        ST_BLK_RANGE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PG_FREE    = 2'd0,
        PG_VALID   = 2'd1,
        PG_INVALID = 2'd2,
        PG_UNUSED  = 2'd3
    } t_page;

    // one datapath operation per cycle, chosen by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_DISPATCH,
        OP_WMAP,
        OP_WINV,
        OP_SRD,
        OP_SCHK,
        OP_RMAP,
        OP_RST,
        OP_EUPD,
        OP_EFREE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic lpa_bad;
        logic blk_bad;
        logic mapped;
        logic scan_hit;
        logic scan_last;
        logic clr_last;
        logic efree_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/pmft_ram.sv]
// ----------------------------------------------------------------------------
// pmft_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pmft_ctrl.sv]
// ----------------------------------------------------------------------------
// pmft_ctrl
// Sequencer: clearing pass, command dispatch, free page scan, block erase.
// ----------------------------------------------------------------------------
module pmft_ctrl
    import pmft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_WMAP     = 13'b0000000001000,
        S_WINV     = 13'b0000000010000,
        S_SRD      = 13'b0000000100000,
        S_SCHK     = 13'b0000001000000,
        S_RMAP     = 13'b0000010000000,
        S_RST      = 13'b0000100000000,
        S_EUPD     = 13'b0001000000000,
        S_EFREE    = 13'b0010000000000,
        S_EMIT     = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ctl.op  = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.op = OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_ctl.op = OP_DISPATCH;
                unique case (i_sts.cmd)
                    CMD_WRITE: n_state = i_sts.lpa_bad ? S_EMIT : S_WMAP;
                    CMD_READ:  n_state = i_sts.lpa_bad ? S_EMIT : S_RMAP;
                    CMD_ERASE: n_state = i_sts.blk_bad ? S_EMIT : S_EUPD;
                    default:   n_state = S_EMIT;
                endcase
            end
            S_WMAP: begin
                o_ctl.op = OP_WMAP;
                n_state  = i_sts.mapped ? S_WINV : S_SRD;
            end
            S_WINV: begin
                o_ctl.op = OP_WINV;
                n_state  = S_SRD;
            end
            S_SRD: begin
                o_ctl.op = OP_SRD;
                n_state  = S_SCHK;
            end
            S_SCHK: begin
                o_ctl.op = OP_SCHK;
                if (i_sts.scan_hit || i_sts.scan_last) n_state = S_EMIT;
                else n_state = S_SRD;
            end
            S_RMAP: begin
                o_ctl.op = OP_RMAP;
                n_state  = i_sts.mapped ? S_RST : S_EMIT;
            end
            S_RST: begin
                o_ctl.op = OP_RST;
                n_state  = S_EMIT;
            end
            S_EUPD: begin
                o_ctl.op = OP_EUPD;
                n_state  = S_EFREE;
            end
            S_EFREE: begin
                o_ctl.op = OP_EFREE;
                if (i_sts.efree_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

[rtl/pmft_dp.sv]
// ----------------------------------------------------------------------------
// pmft_dp
// Datapath: map, page state and per block counter stores, result registers.
// ----------------------------------------------------------------------------
module pmft_dp
    import pmft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_logical_page,
    input  logic [15:0] i_block_number,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [16:0] o_physical_page,
    output logic [9:0]  o_block_of_page,
    output logic [6:0]  o_page_in_block,
    output logic [7:0]  o_inv_count,
    output logic [31:0] o_erase_cycles
);

    logic [17:0]      r_lpc;
    t_cmd             r_cmd;
    logic [31:0]      r_lpa;
    logic [15:0]      r_blk;
    logic [PBA_W-1:0] r_clr, r_wp, r_scan, r_cnt;
    logic [OFF_W-1:0] r_off;
    logic [BLK_W-1:0] r_oblk;
    t_status          r_res_status;
    logic [PBA_W-1:0] r_res_pba;
    logic [BLK_W-1:0] r_res_blk;
    logic [7:0]       r_res_inv;
    logic [31:0]      r_res_erc;
    logic             r_o_valid;
    logic [2:0]       r_o_status;
    logic [16:0]      r_o_pba;
    logic [9:0]       r_o_blk;
    logic [6:0]       r_o_off;
    logic [7:0]       r_o_inv;
    logic [31:0]      r_o_erc;

    logic             clearing, blk_clear;
    logic [17:0]      eff_lpc;
    logic             map_we, ps_we, inv_we, erc_we;
    logic [PBA_W-1:0] map_waddr, ps_waddr, ps_raddr;
    logic [MAP_W-1:0] map_wdata, map_rd;
    logic [1:0]       ps_wdata, ps_rd;
    logic [BLK_W-1:0] inv_waddr, erc_waddr;
    logic [7:0]       inv_wdata, inv_rd, inv_next;
    logic [31:0]      erc_wdata, erc_rd, erc_next;

    assign clearing  = (i_ctl.op == OP_CLEAR);
    assign blk_clear = clearing && (32'(r_clr) < 32'(BLOCK_TOTAL));
    assign eff_lpc   = (r_lpc > PHYS_COUNT) ? PHYS_COUNT : r_lpc;
    assign inv_next  = (inv_rd == INV_MAX) ? INV_MAX : inv_rd + 8'd1;
    assign erc_next  = (erc_rd == ERASE_MAX) ? ERASE_MAX : erc_rd + 32'd1;

    // store ports
    always_comb begin
        map_we    = clearing || (i_ctl.op == OP_SCHK && ps_rd == PG_FREE);
        map_waddr = clearing ? r_clr : r_lpa[PBA_W-1:0];
        map_wdata = clearing ? '0 : {1'b1, r_scan};

        ps_we    = 1'b0;
        ps_waddr = r_scan;
        ps_wdata = PG_FREE;
        priority if (clearing) begin
            ps_we    = 1'b1;
            ps_waddr = r_clr;
        end else if (i_ctl.op == OP_WMAP && map_rd[PBA_W]) begin
            ps_we    = 1'b1;
            ps_waddr = map_rd[PBA_W-1:0];
            ps_wdata = PG_INVALID;
        end else if (i_ctl.op == OP_SCHK && ps_rd == PG_FREE) begin
            ps_we    = 1'b1;
            ps_wdata = PG_VALID;
        end else if (i_ctl.op == OP_EFREE) begin
            ps_we    = 1'b1;
            ps_waddr = {r_blk[BLK_W-1:0], r_off};
        end
        ps_raddr = (i_ctl.op == OP_RMAP) ? map_rd[PBA_W-1:0] : r_scan;

        inv_we    = blk_clear || i_ctl.op == OP_WINV || i_ctl.op == OP_EUPD;
        inv_waddr = r_blk[BLK_W-1:0];
        inv_wdata = '0;
        if (blk_clear) inv_waddr = r_clr[BLK_W-1:0];
        if (i_ctl.op == OP_WINV) begin
            inv_waddr = r_oblk;
            inv_wdata = inv_next;
        end

        erc_we    = blk_clear || i_ctl.op == OP_EUPD;
        erc_waddr = blk_clear ? r_clr[BLK_W-1:0] : r_blk[BLK_W-1:0];
        erc_wdata = blk_clear ? '0 : erc_next;
    end

    pmft_ram #(.WIDTH(MAP_W), .DEPTH(PHYS_PAGES)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(r_lpa[PBA_W-1:0]), .o_rdata(map_rd)
    );

    pmft_ram #(.WIDTH(2), .DEPTH(PHYS_PAGES)) u_page (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_waddr), .i_wdata(ps_wdata),
        .i_raddr(ps_raddr), .o_rdata(ps_rd)
    );

    pmft_ram #(.WIDTH(8), .DEPTH(BLOCK_TOTAL)) u_inv (
        .i_clk(i_clk), .i_we(inv_we), .i_waddr(inv_waddr), .i_wdata(inv_wdata),
        .i_raddr(map_rd[PBA_W-1:OFF_W]), .o_rdata(inv_rd)
    );

    pmft_ram #(.WIDTH(32), .DEPTH(BLOCK_TOTAL)) u_erc (
        .i_clk(i_clk), .i_we(erc_we), .i_waddr(erc_waddr), .i_wdata(erc_wdata),
        .i_raddr(r_blk[BLK_W-1:0]), .o_rdata(erc_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpc     <= LPC_RESET;
            r_clr     <= '0;
            r_wp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_lpc <= i_cfg_data;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (i_ctl.op == OP_SCHK && ps_rd == PG_FREE) r_wp <= r_scan + 1'b1;
            if (i_ctl.op == OP_EMIT) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_command);
                r_lpa <= i_logical_page;
                r_blk <= i_block_number;
            end
            OP_DISPATCH: begin
                r_res_pba    <= '0;
                r_res_blk    <= '0;
                r_res_inv    <= '0;
                r_res_erc    <= '0;
                r_scan       <= r_wp;
                r_cnt        <= '0;
                r_off        <= '0;
                if ((r_cmd == CMD_WRITE || r_cmd == CMD_READ) && o_sts.lpa_bad)
                    r_res_status <= ST_RANGE;
                else if (r_cmd == CMD_ERASE && o_sts.blk_bad)
                    r_res_status <= ST_BLK_RANGE;
                else
                    r_res_status <= ST_OK;
            end
            OP_WMAP: r_oblk <= map_rd[PBA_W-1:OFF_W];
            OP_WINV: r_res_inv <= inv_next;
            OP_SCHK: begin
                if (ps_rd == PG_FREE) begin
                    r_res_pba <= r_scan;
                    r_res_blk <= r_scan[PBA_W-1:OFF_W];
                end else if (o_sts.scan_last) begin
                    r_res_status <= ST_NO_FREE;
                end else begin
                    r_scan <= r_scan + 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            OP_RMAP: begin
                if (map_rd[PBA_W]) begin
                    r_res_pba <= map_rd[PBA_W-1:0];
                    r_res_blk <= map_rd[PBA_W-1:OFF_W];
                end else begin
                    r_res_status <= ST_UNMAPPED;
                end
            end
            OP_RST: if (ps_rd != PG_VALID) r_res_status <= ST_NOT_VALID;
            OP_EUPD: begin
                r_res_erc <= erc_next;
                r_res_blk <= r_blk[BLK_W-1:0];
            end
            OP_EFREE: r_off <= r_off + 1'b1;
            OP_EMIT: begin
                r_o_status <= r_res_status;
                r_o_pba    <= 17'(r_res_pba);
                r_o_blk    <= 10'(r_res_blk);
                r_o_off    <= 7'(r_res_pba[OFF_W-1:0]);
                r_o_inv    <= r_res_inv;
                r_o_erc    <= r_res_erc;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.lpa_bad    = (r_lpa >= 32'(eff_lpc));
        o_sts.blk_bad    = (32'(r_blk) >= 32'(BLOCK_TOTAL));
        o_sts.mapped     = map_rd[PBA_W];
        o_sts.scan_hit   = (ps_rd == PG_FREE);
        o_sts.scan_last  = (r_cnt == PBA_W'(PHYS_PAGES - 1));
        o_sts.clr_last   = (r_clr == PBA_W'(PHYS_PAGES - 1));
        o_sts.efree_last = (r_off == OFF_W'(PAGES_IN_BLOCK - 1));
        o_sts.out_free   = !r_o_valid || !i_stall;
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_physical_page = r_o_pba;
    assign o_block_of_page = r_o_blk;
    assign o_page_in_block = r_o_off;
    assign o_inv_count     = r_o_inv;
    assign o_erase_cycles  = r_o_erc;

endmodule

[rtl/page_mapped_flash_translation_top.sv]
// ----------------------------------------------------------------------------
// page_mapped_flash_translation_top
// Page level flash translation: write allocates and maps, read looks up,
// erase frees a block and counts its erase cycles.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  command  | in        | i_valid / o_stall      | command, logical_page, block_number
//  result   | out       | o_valid / i_stall      | status .. erase_cycles
//  config   | in        | i_cfg_valid/o_cfg_ready| logical_page_count
//
//  after reset a clearing pass runs; o_stall is high meanwhile
//  write: map lookup, old page invalidated if it was mapped, then a free page
//  scan that probes pages in turn; read: map lookup, then a page state check if
//  mapped; out of range or unused command: straight to the result; erase: erase
//  count update, then freeing one page state entry per cycle through the single write port
//  one transaction is worked at a time; a result waits in the output register
//  while the next command is taken, and a held result delays the next one
// ----------------------------------------------------------------------------
module page_mapped_flash_translation_top
    import pmft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_logical_page,
    input  logic [15:0] i_block_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [16:0] o_physical_page,
    output logic [9:0]  o_block_of_page,
    output logic [6:0]  o_page_in_block,
    output logic [7:0]  o_inv_count,
    output logic [31:0] o_erase_cycles,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [17:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pmft_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sts(sts), .o_ctl(ctl)
    );

    pmft_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_command(i_command), .i_logical_page(i_logical_page),
        .i_block_number(i_block_number),
        .i_cfg_we(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .i_stall(i_stall), .o_valid(o_valid), .o_status(o_status),
        .o_physical_page(o_physical_page), .o_block_of_page(o_block_of_page),
        .o_page_in_block(o_page_in_block), .o_inv_count(o_inv_count),
        .o_erase_cycles(o_erase_cycles)
    );

endmodule
